[src/tpsg_pkg.sv]
`default_nettype none

package tpsg_pkg;

    // Fixed field widths
    localparam int DATA_W    = 8;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET  = 1'd1;

    // Phase spacing between outputs and rounding constant
    localparam logic [DATA_W-1:0] PHASE_SHIFT = 8'h55;
    localparam logic [PROD_W:0]   ROUND_HALF  = 17'h00040;
    localparam int                OUT_LIMIT   = 127;

    // Phase select for the shared multiplier
    localparam logic [1:0] PH_U = 2'd0;
    localparam logic [1:0] PH_V = 2'd1;
    localparam logic [1:0] PH_W = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_inc;   // multiply gain by frequency, capture amplitude
        logic       upd_acc;    // advance the phase accumulator
        logic [1:0] mul_sel;    // which phase feeds the multiplier
        logic       mul_en;     // register a phase product
        logic       save_u;     // keep the finished U value
        logic       save_v;     // keep the finished V value
        logic       load_out;   // move U, V, W into the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

    // Quarter wave of round(127*sin(2*pi*k/256)), k = 0..64
    localparam logic [6:0] QUARTER_SINE [0:64] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
        7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
        7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
        7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
        7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
        7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
        7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
        7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
        7'd127
    };

    // Full-wave sine from the quarter table, mirrored by quadrant
    function automatic logic signed [DATA_W-1:0] sine_at(input logic [DATA_W-1:0] idx);
        logic [6:0] r;
        logic [6:0] mag;
        r = {1'b0, idx[5:0]};
        if (idx[6]) begin
            mag = QUARTER_SINE[7'd64 - r];
        end else begin
            mag = QUARTER_SINE[r];
        end
        if (idx[7]) begin
            sine_at = -$signed({1'b0, mag});
        end else begin
            sine_at = $signed({1'b0, mag});
        end
    endfunction

endpackage

`default_nettype wire

[src/tpsg_if.sv]
`default_nettype none

// Input request channel: amplitude and frequency for one tick
interface tpsg_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] amplitude;
    logic signed [7:0] frequency;

    modport source (output valid, amplitude, frequency, input ready);
    modport sink   (input valid, amplitude, frequency, output ready);
endinterface

// Output request channel: the three phase values
interface tpsg_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] phase_u;
    logic signed [7:0] phase_v;
    logic signed [7:0] phase_w;

    modport source (output valid, phase_u, phase_v, phase_w, input ready);
    modport sink   (input valid, phase_u, phase_v, phase_w, output ready);
endinterface

`default_nettype wire

[src/tpsg_ctrl.sv]
`default_nettype none

module tpsg_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire tpsg_pkg::t_status i_status,
    output tpsg_pkg::t_cmd         o_cmd
);
    import tpsg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_U    = 3'd2;
    localparam logic [2:0] S_V    = 3'd3;
    localparam logic [2:0] S_W    = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Sequence one request through the shared multiplier
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_inc = w_accept;
                if (w_accept) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.upd_acc = 1'b1;
                n_state       = S_U;
            end
            S_U: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = PH_U;
                n_state       = S_V;
            end
            S_V: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = PH_V;
                o_cmd.save_u  = 1'b1;
                n_state       = S_W;
            end
            S_W: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = PH_W;
                o_cmd.save_v  = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // hold the last product until the output register frees up
                o_cmd.load_out = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted request always starts the accumulator update next
    a_accept_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_ACC))
        else $error("accepted request did not advance to accumulator update");

    // Output is only loaded when the output register can take it
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("output loaded while output register busy");

    // A finished request returns to idle once the output is loaded
    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after output load");

    // Only one datapath step is commanded at a time
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_inc, o_cmd.upd_acc, o_cmd.mul_en, o_cmd.load_out}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

[src/tpsg_dp.sv]
`default_nettype none

module tpsg_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tpsg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tpsg_pkg::DATA_W-1:0]        i_cfg_data,
    input  wire logic signed [tpsg_pkg::DATA_W-1:0] i_amplitude,
    input  wire logic signed [tpsg_pkg::DATA_W-1:0] i_frequency,
    input  wire tpsg_pkg::t_cmd                     i_cmd,
    output tpsg_pkg::t_status                       o_status,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [tpsg_pkg::DATA_W-1:0]      o_phase_u,
    output logic signed [tpsg_pkg::DATA_W-1:0]      o_phase_v,
    output logic signed [tpsg_pkg::DATA_W-1:0]      o_phase_w
);
    import tpsg_pkg::*;

    // Configuration and state
    logic signed [DATA_W-1:0] r_gain;
    logic signed [DATA_W-1:0] r_offset;
    logic        [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] r_amp;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_u;
    logic signed [DATA_W-1:0] r_v;
    logic                     r_out_valid;

    logic        [DATA_W-1:0] w_idx;
    logic signed [DATA_W-1:0] w_sine;
    logic signed [DATA_W-1:0] w_mul_a;
    logic signed [DATA_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W:0]   w_round;
    logic signed [PROD_W:0]   w_shift;
    logic signed [9:0]        w_scaled;
    logic signed [10:0]       w_sum;
    logic signed [DATA_W-1:0] w_clamped;

    // Pick the table angle for the current phase
    always_comb begin
        case (i_cmd.mul_sel)
            PH_U:    w_idx = r_acc;
            PH_V:    w_idx = r_acc - PHASE_SHIFT;
            default: w_idx = r_acc + PHASE_SHIFT;
        endcase
    end

    assign w_sine  = sine_at(w_idx);

    // Shared multiplier: gain*frequency, then amplitude*sine per phase
    assign w_mul_a = i_cmd.load_inc ? r_gain : r_amp;
    assign w_mul_b = i_cmd.load_inc ? i_frequency : w_sine;
    assign w_prod  = w_mul_a * w_mul_b;

    // Round the registered product with a floor shift
    assign w_round  = {r_prod[PROD_W-1], r_prod} + ROUND_HALF;
    assign w_shift  = w_round >>> 7;
    assign w_scaled = w_shift[9:0];

    // Add offset and clamp symmetrically
    assign w_sum = {w_scaled[9], w_scaled} + {{3{r_offset[DATA_W-1]}}, r_offset};
    always_comb begin
        if (w_sum > 11'sd127) begin
            w_clamped = 8'sd127;
        end else if (w_sum < -11'sd127) begin
            w_clamped = -8'sd127;
        end else begin
            w_clamped = w_sum[DATA_W-1:0];
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PHASE_GAIN: r_gain   <= i_cfg_data;
                REG_DC_OFFSET:  r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Phase accumulator, wraps modulo 256
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.upd_acc) begin
            r_acc <= r_acc + w_scaled[DATA_W-1:0];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_inc) begin
            r_amp <= i_amplitude;
        end
        if (i_cmd.load_inc || i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.save_u) begin
            r_u <= w_clamped;
        end
        if (i_cmd.save_v) begin
            r_v <= w_clamped;
        end
        if (i_cmd.load_out) begin
            o_phase_u <= r_u;
            o_phase_v <= r_v;
            o_phase_w <= w_clamped;
        end
    end

    // Output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[src/three_phase_sine_generator_q7.sv]
`default_nettype none

// Channel    Dir  Handshake          Payload
// i_in       in   valid / ready      amplitude, frequency (signed Q7)
// o_out      out  valid / ready      phase_u, phase_v, phase_w (signed Q7)
// i_cfg_*    in   write enable only  index 0 phase_gain, 1 dc_offset
//
// One request goes from acceptance to a valid output through the increment
// product, the accumulator add, the three phase products and the load of the
// output register, all through one 8x8 multiplier.
// A new request is taken only once the previous one has left the datapath.
// The output register lets a result wait while the next request is accepted;
// the controller holds before the output load while that register is full.
// Reset is synchronous, active low; it clears the phase and both registers.

module three_phase_sine_generator_q7 (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tpsg_in_if.sink                             i_in,
    tpsg_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [tpsg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tpsg_pkg::DATA_W-1:0]    i_cfg_data
);
    import tpsg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tpsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tpsg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_amplitude (i_in.amplitude),
        .i_frequency (i_in.frequency),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_phase_u   (o_out.phase_u),
        .o_phase_v   (o_out.phase_v),
        .o_phase_w   (o_out.phase_w)
    );

endmodule

`default_nettype wire

[sim/tb_three_phase_sine_generator_q7.sv]
module tb_three_phase_sine_generator_q7;
    timeunit 1ns;
    timeprecision 1ps;

    import tpsg_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 32;
    localparam int TICKS_PER_SET = 100;

    // One output request: the three phase values
    typedef struct packed {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] w;
    } t_phase_triplet;

    // Quarter wave of round(127*sin(2*pi*k/256)), k = 0..64
    localparam int QTR_WAVE [0:64] = '{
        0, 3, 6, 9, 12, 16, 19, 22, 25, 28, 31, 34, 37, 40, 43, 46,
        49, 51, 54, 57, 60, 63, 65, 68, 71, 73, 76, 78, 81, 83, 85, 88,
        90, 92, 94, 96, 98, 100, 102, 104, 106, 107, 109, 111, 112, 113, 115, 116,
        117, 118, 120, 121, 122, 122, 123, 124, 125, 125, 126, 126, 126, 127, 127, 127,
        127
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    tpsg_in_if  in_if();
    tpsg_out_if out_if();

    // Shadow of the block's state and registers
    logic [DATA_W-1:0]        phase_acc = '0;
    logic signed [DATA_W-1:0] gain_shadow = '0;
    logic signed [DATA_W-1:0] offset_shadow = '0;

    t_phase_triplet expected_phases [$];

    int error_count = 0;
    int request_count = 0;
    int result_count = 0;
    int reg_write_count = 0;
    int cycle_count = 0;
    int in_idle_pct = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;

    three_phase_sine_generator_q7 u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        in_if.valid = 1'b0;
        in_if.amplitude = '0;
        in_if.frequency = '0;
        out_if.ready = 1'b0;
    end

    always #CLK_HALF i_clk = ~i_clk;

    // Signed sine sample at an 8-bit phase index
    function automatic int wave_sample(input logic [DATA_W-1:0] idx);
        int mag;
        if (idx[6]) begin
            mag = QTR_WAVE[64 - int'(idx[5:0])];
        end else begin
            mag = QTR_WAVE[int'(idx[5:0])];
        end
        return idx[7] ? -mag : mag;
    endfunction

    // Scale by amplitude with rounding, add offset, clamp to +/-127
    function automatic logic signed [DATA_W-1:0] scale_clamp(
        input logic signed [DATA_W-1:0] amp,
        input logic [DATA_W-1:0]        idx
    );
        int level;
        level = ((int'(amp) * wave_sample(idx) + 64) >>> 7) + int'(offset_shadow);
        if (level > OUT_LIMIT) begin
            level = OUT_LIMIT;
        end
        if (level < -OUT_LIMIT) begin
            level = -OUT_LIMIT;
        end
        return level[DATA_W-1:0];
    endfunction

    // Advance the shadow phase and form the three expected outputs
    function automatic t_phase_triplet predict_phases(
        input logic signed [DATA_W-1:0] amp,
        input logic signed [DATA_W-1:0] freq
    );
        int incr;
        logic [DATA_W-1:0] phi;
        logic [DATA_W-1:0] phi_v;
        logic [DATA_W-1:0] phi_w;
        t_phase_triplet res;
        incr = (int'(gain_shadow) * int'(freq) + 64) >>> 7;
        phase_acc = phase_acc + incr[DATA_W-1:0];
        phi = phase_acc;
        phi_v = phi - PHASE_SHIFT;
        phi_w = phi + PHASE_SHIFT;
        res.u = scale_clamp(amp, phi);
        res.v = scale_clamp(amp, phi_v);
        res.w = scale_clamp(amp, phi_w);
        return res;
    endfunction

    // Drive output ready with random stalls
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Check finished results first, then queue predictions for new requests
    always @(posedge i_clk) begin
        t_phase_triplet exp_ph;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                result_count++;
                if (expected_phases.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result u=%0d v=%0d w=%0d", $time,
                             out_if.phase_u, out_if.phase_v, out_if.phase_w);
                end else begin
                    exp_ph = expected_phases.pop_front();
                    if (out_if.phase_u !== exp_ph.u) begin
                        error_count++;
                        $display("%0t: phase_u expected %0d actual %0d", $time,
                                 exp_ph.u, out_if.phase_u);
                    end
                    if (out_if.phase_v !== exp_ph.v) begin
                        error_count++;
                        $display("%0t: phase_v expected %0d actual %0d", $time,
                                 exp_ph.v, out_if.phase_v);
                    end
                    if (out_if.phase_w !== exp_ph.w) begin
                        error_count++;
                        $display("%0t: phase_w expected %0d actual %0d", $time,
                                 exp_ph.w, out_if.phase_w);
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                request_count++;
                expected_phases.push_back(predict_phases(in_if.amplitude, in_if.frequency));
            end
        end
    end

    // Send one request, with random gaps ahead of it
    task automatic send_tick(input logic signed [DATA_W-1:0] amp,
                             input logic signed [DATA_W-1:0] freq);
        while ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.amplitude <= amp;
        in_if.frequency <= freq;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain_block();
        in_if.valid <= 1'b0;
        // let the checker queue the last accepted request first
        @(posedge i_clk);
        while (expected_phases.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value);
        drain_block();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_PHASE_GAIN) begin
            gain_shadow = value;
        end else if (idx == REG_DC_OFFSET) begin
            offset_shadow = value;
        end
        reg_write_count++;
    endtask

    // Registers at reset: zero gain holds the phase at zero
    task automatic test_reset_state();
        send_tick(8'sd127, 8'sd127);
        send_tick(-8'sd128, -8'sd128);
        send_tick(8'sd0, 8'sd0);
        send_tick(8'sd1, -8'sd1);
    endtask

    // Extreme increments, including the one that overflows to -128
    task automatic test_increment_extremes();
        write_register(REG_PHASE_GAIN, 8'h80);
        write_register(REG_DC_OFFSET, 8'h00);
        send_tick(-8'sd128, -8'sd128);
        send_tick(8'sd127, 8'sd127);
        send_tick(8'sd127, -8'sd1);
        write_register(REG_PHASE_GAIN, 8'h7f);
        send_tick(8'sd127, 8'sd127);
        send_tick(-8'sd128, -8'sd128);
        send_tick(8'sd64, 8'sd1);
    endtask

    // Offsets at both ends drive the outputs into the clamp
    task automatic test_clamp_limits();
        write_register(REG_PHASE_GAIN, 8'h40);
        write_register(REG_DC_OFFSET, 8'h7f);
        send_tick(8'sd127, 8'sd10);
        send_tick(-8'sd128, 8'sd20);
        send_tick(8'sd0, 8'sd5);
        write_register(REG_DC_OFFSET, 8'h80);
        send_tick(8'sd127, 8'sd33);
        send_tick(-8'sd128, -8'sd77);
        send_tick(8'sd1, 8'sd64);
    endtask

    // Random requests over several register settings, extremes first
    task automatic test_random_ticks();
        logic [DATA_W-1:0] gain_val;
        logic [DATA_W-1:0] offs_val;
        logic [DATA_W-1:0] amp;
        logic [DATA_W-1:0] freq;
        int pick;
        for (int set = 0; set < 8; set++) begin
            case (set)
                0: begin
                    gain_val = 8'h7f;
                    offs_val = 8'h80;
                end
                1: begin
                    gain_val = 8'h80;
                    offs_val = 8'h7f;
                end
                2: begin
                    gain_val = 8'h80;
                    offs_val = 8'h00;
                end
                3: begin
                    gain_val = 8'h7f;
                    offs_val = 8'h7f;
                end
                default: begin
                    gain_val = 8'($urandom_range(255));
                    offs_val = 8'($urandom_range(255));
                end
            endcase
            write_register(REG_PHASE_GAIN, gain_val);
            write_register(REG_DC_OFFSET, offs_val);
            // hold both sides busy for one whole set
            if (set == 2) begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct = IDLE_PCT;
                out_idle_pct = IDLE_PCT;
            end
            for (int n = 0; n < TICKS_PER_SET; n++) begin
                amp = 8'($urandom_range(255));
                freq = 8'($urandom_range(255));
                pick = $urandom_range(9);
                if (pick == 0) begin
                    amp = ($urandom_range(1) == 1) ? 8'h7f : 8'h80;
                end else if (pick == 1) begin
                    freq = ($urandom_range(1) == 1) ? 8'h7f : 8'h80;
                end
                send_tick(amp, freq);
            end
        end
        in_idle_pct = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_increment_extremes();
        test_clamp_limits();
        test_random_ticks();

        drain_block();
        if (expected_phases.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, expected_phases.size());
        end
        $display("Covered %0d requests and %0d results over %0d register writes,",
                 request_count, result_count, reg_write_count);
        $display("with gain and offset at both extremes and random stalls on both sides.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
